[src/y86ie_pkg.sv]
// Shared constants and port types of the Y86 executor.
// Used by the core, memory, register file and checker; depends on nothing.
`default_nettype none
package y86ie_pkg;

   localparam int MEM_BYTES = 8192;
   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam logic [31:0] BYTE_LIM = 32'(MEM_BYTES);
   localparam logic [31:0] WORD_LIM = 32'(MEM_BYTES - 4);

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_EXEC = 2'd1;
   localparam logic [1:0] ACT_REG  = 2'd2;
   localparam logic [1:0] ACT_WORD = 2'd3;

   localparam logic [1:0] ST_AOK = 2'd0;
   localparam logic [1:0] ST_HLT = 2'd1;
   localparam logic [1:0] ST_ADR = 2'd2;
   localparam logic [1:0] ST_INS = 2'd3;

   localparam logic [3:0] I_HALT   = 4'h0;
   localparam logic [3:0] I_NOP    = 4'h1;
   localparam logic [3:0] I_RRMOV  = 4'h2;
   localparam logic [3:0] I_IRMOV  = 4'h3;
   localparam logic [3:0] I_RMMOV  = 4'h4;
   localparam logic [3:0] I_MRMOV  = 4'h5;
   localparam logic [3:0] I_OPL    = 4'h6;
   localparam logic [3:0] I_JXX    = 4'h7;
   localparam logic [3:0] I_CALL   = 4'h8;
   localparam logic [3:0] I_RET    = 4'h9;
   localparam logic [3:0] I_PUSH   = 4'hA;
   localparam logic [3:0] I_POP    = 4'hB;

   localparam logic [2:0] REG_ESP = 3'd4;
   localparam logic [2:0] CC_RESET = 3'b100;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   typedef struct packed {
      logic        we;
      logic [2:0]  waddr;
      logic [31:0] wdata;
      logic [2:0]  raddr_a;
      logic [2:0]  raddr_b;
   } rf_req_type;

endpackage
`default_nettype wire

[src/y86ie_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`default_nettype none
interface y86ie_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [12:0] address;
   logic [7:0] load_byte;
   logic [2:0] register_index;
   modport source (output valid, action, address, load_byte, register_index, input ready);
   modport sink (input valid, action, address, load_byte, register_index, output ready);
endinterface

interface y86ie_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [31:0]        program_counter;
   logic [2:0]         flags;
   logic signed [31:0] read_data;
   modport source (output valid, status, program_counter, flags, read_data, input ready);
   modport sink (input valid, status, program_counter, flags, read_data, output ready);
endinterface
`default_nettype wire

[src/y86_instruction_executor.sv]
// Sequential Y86 core: sequencer, byte memory, register file and ALU.
// After reset a clearing pass zeroes memory and registers; no request is taken until
// it ends. The single byte-wide memory port sets the pace: it moves one byte per cycle,
// an instruction fetches up to six bytes and moves up to four data bytes, and each
// register file write takes its own step; a response that awaits transfer holds off
// the next request.
// Depends on y86ie_pkg, y86ie_if, y86ie_mem, y86ie_regs and y86ie_alu.
`default_nettype none
module y86_instruction_executor (
   input  wire logic   clock,
   input  wire logic   reset,
   y86ie_req_if.sink   req_ch,
   y86ie_rsp_if.source rsp_ch
);
   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_WR   = 4'd3;
   localparam logic [3:0] S_X0   = 4'd4;
   localparam logic [3:0] S_X1   = 4'd5;
   localparam logic [3:0] S_X2   = 4'd6;
   localparam logic [3:0] S_X3   = 4'd7;
   localparam logic [3:0] S_X4   = 4'd8;
   localparam logic [3:0] S_X5   = 4'd9;
   localparam logic [3:0] S_X6   = 4'd10;
   localparam logic [3:0] S_FSP  = 4'd11;
   localparam logic [3:0] S_FR   = 4'd12;
   localparam logic [3:0] S_DONE = 4'd13;
   localparam logic [3:0] S_REG  = 4'd14;
   localparam logic [3:0] S_WD   = 4'd15;
   localparam int AW = y86ie_pkg::MEM_AW;

   logic [3:0] state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [31:0] fa_ff, fa_in;
   logic [2:0] n_ff, n_in, i_ff, i_in;
   logic pend_ff, pend_in;
   logic [1:0] pidx_ff, pidx_in;
   logic [31:0] buf_ff, buf_in, wd_ff, wd_in;
   logic [3:0] ret_ff, ret_in;
   logic [3:0] icode_ff, icode_in, ifun_ff, ifun_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [31:0] np_ff, np_in, imm_ff, imm_in, sp_ff, sp_in, rval_ff, rval_in;
   logic dosp_ff, dosp_in, dor_ff, dor_in;
   logic [3:0] rid_ff, rid_in;
   logic [1:0] st_ff, st_in;
   logic [31:0] data_ff, data_in, pc_ff, pc_in;
   logic commit_ff, commit_in;
   logic [2:0] cc_ff, cc_in;
   logic rv_ff, rv_in;
   logic [1:0] rst_ff, rst_in;
   logic [31:0] rpc_ff, rpc_in, rdat_ff, rdat_in;
   logic [2:0] rcc_ff, rcc_in;

   y86ie_pkg::mem_req_type mem_req;
   y86ie_pkg::rf_req_type rf_req;
   logic [7:0] mem_rdata;
   logic [31:0] rd_a, rd_b, val_a, val_b, alu_res, cur_addr, daddr, req_addr;
   logic [2:0] alu_cc;
   logic cond, accept, use_sp, need_regs, need_imm;

   y86ie_mem u_mem (.clock(clock), .mem_req(mem_req), .mem_rdata(mem_rdata));
   y86ie_regs u_regs (.clock(clock), .rf_req(rf_req), .rd_a(rd_a), .rd_b(rd_b));
   y86ie_alu u_alu (
      .ifun(ifun_ff), .val_a(val_a), .val_b(val_b), .cc(cc_ff),
      .result(alu_res), .cc_new(alu_cc), .cond(cond)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rv_ff;
   assign rsp_ch.status = rst_ff;
   assign rsp_ch.program_counter = rpc_ff;
   assign rsp_ch.flags = rcc_ff;
   assign rsp_ch.read_data = rdat_ff;

   assign cur_addr = fa_ff + {29'd0, i_ff};
   assign req_addr = {19'd0, req_ch.address};
   assign use_sp = (icode_ff == y86ie_pkg::I_CALL) || (icode_ff == y86ie_pkg::I_RET)
                   || (icode_ff == y86ie_pkg::I_PUSH) || (icode_ff == y86ie_pkg::I_POP);
   assign val_a = ra_ff[3] ? 32'd0 : rd_a;
   assign val_b = use_sp ? rd_b : (rb_ff[3] ? 32'd0 : rd_b);
   assign daddr = val_b + imm_ff;
   assign need_regs = (icode_ff >= y86ie_pkg::I_RRMOV && icode_ff <= y86ie_pkg::I_OPL)
                      || icode_ff == y86ie_pkg::I_PUSH || icode_ff == y86ie_pkg::I_POP;
   assign need_imm = (icode_ff >= y86ie_pkg::I_IRMOV && icode_ff <= y86ie_pkg::I_MRMOV)
                     || icode_ff == y86ie_pkg::I_JXX || icode_ff == y86ie_pkg::I_CALL;

   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;  fa_in = fa_ff;  n_in = n_ff;  i_in = i_ff;
      pend_in = 1'b0;  pidx_in = pidx_ff;  buf_in = buf_ff;  wd_in = wd_ff;
      ret_in = ret_ff;  icode_in = icode_ff;  ifun_in = ifun_ff;  ra_in = ra_ff;
      rb_in = rb_ff;  np_in = np_ff;  imm_in = imm_ff;  sp_in = sp_ff;  rval_in = rval_ff;
      dosp_in = dosp_ff;  dor_in = dor_ff;  rid_in = rid_ff;  st_in = st_ff;
      data_in = data_ff;  pc_in = pc_ff;  commit_in = commit_ff;  cc_in = cc_ff;
      rv_in = rv_ff && !rsp_ch.ready;  rst_in = rst_ff;  rpc_in = rpc_ff;
      rdat_in = rdat_ff;  rcc_in = rcc_ff;
      mem_req.we = 1'b0;  mem_req.addr = cur_addr[AW-1:0];  mem_req.wdata = 8'd0;
      rf_req.we = 1'b0;  rf_req.waddr = '0;  rf_req.wdata = '0;
      rf_req.raddr_a = ra_ff[2:0];
      rf_req.raddr_b = use_sp ? y86ie_pkg::REG_ESP : rb_ff[2:0];

      unique case (state_ff)
         S_CLR: begin
            mem_req.we = 1'b1;
            mem_req.addr = clr_ff;
            if (clr_ff < AW'(8)) begin
               rf_req.we = 1'b1;
               rf_req.waddr = clr_ff[2:0];
            end
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(y86ie_pkg::MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rf_req.raddr_a = req_ch.register_index;
            mem_req.addr = req_ch.address[AW-1:0];
            mem_req.wdata = req_ch.load_byte;
            st_in = y86ie_pkg::ST_AOK;
            data_in = '0;
            commit_in = 1'b0;
            dosp_in = 1'b0;
            dor_in = 1'b0;
            if (accept) begin
               unique case (req_ch.action)
                  y86ie_pkg::ACT_LOAD: begin
                     mem_req.we = req_addr < y86ie_pkg::BYTE_LIM;
                     state_in = S_DONE;
                  end
                  y86ie_pkg::ACT_EXEC: state_in = S_X0;
                  y86ie_pkg::ACT_REG: state_in = S_REG;
                  default: begin
                     if (req_addr <= y86ie_pkg::WORD_LIM) begin
                        fa_in = req_addr;  n_in = 3'd4;  i_in = 3'd0;
                        buf_in = '0;  ret_in = S_WD;  state_in = S_RD;
                     end else begin
                        st_in = y86ie_pkg::ST_ADR;
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            if (i_ff < n_ff) begin
               pend_in = 1'b1;
               pidx_in = i_ff[1:0];
               i_in = i_ff + 3'd1;
            end
            if (pend_ff) begin
               buf_in[8*pidx_ff +: 8] = mem_rdata;
               if (i_ff == n_ff) begin
                  state_in = ret_ff;
               end
            end
         end
         S_WR: begin
            mem_req.we = 1'b1;
            mem_req.wdata = wd_ff[8*i_ff[1:0] +: 8];
            i_in = i_ff + 3'd1;
            if (i_ff == 3'd3) begin
               state_in = ret_ff;
            end
         end
         S_X0: begin
            if (pc_ff < y86ie_pkg::BYTE_LIM) begin
               fa_in = pc_ff;  n_in = 3'd1;  i_in = 3'd0;  buf_in = '0;
               ret_in = S_X1;  state_in = S_RD;
            end else begin
               st_in = y86ie_pkg::ST_ADR;
               state_in = S_DONE;
            end
         end
         S_X1: begin
            icode_in = buf_ff[7:4];
            ifun_in = buf_ff[3:0];
            ra_in = 4'hF;
            rb_in = 4'hF;
            imm_in = '0;
            np_in = pc_ff + 32'd1;
            state_in = S_X2;
            if (buf_ff[7:4] > y86ie_pkg::I_POP) begin
               st_in = y86ie_pkg::ST_INS;
               state_in = S_DONE;
            end
         end
         S_X2: begin
            state_in = S_X3;
            if (need_regs) begin
               if (np_ff < y86ie_pkg::BYTE_LIM) begin
                  fa_in = np_ff;  n_in = 3'd1;  i_in = 3'd0;  buf_in = '0;
                  ret_in = S_X3;  state_in = S_RD;
               end else begin
                  st_in = y86ie_pkg::ST_ADR;
                  state_in = S_DONE;
               end
            end
         end
         S_X3: begin
            state_in = S_X4;
            if (need_regs) begin
               ra_in = buf_ff[7:4];
               rb_in = buf_ff[3:0];
               np_in = np_ff + 32'd1;
            end
         end
         S_X4: begin
            state_in = S_X5;
            if (need_imm) begin
               if (np_ff <= y86ie_pkg::WORD_LIM) begin
                  fa_in = np_ff;  n_in = 3'd4;  i_in = 3'd0;  buf_in = '0;
                  ret_in = S_X6;  state_in = S_RD;
               end else begin
                  st_in = y86ie_pkg::ST_ADR;
                  state_in = S_DONE;
               end
            end
         end
         S_X6: begin
            imm_in = buf_ff;
            np_in = np_ff + 32'd4;
            state_in = S_X5;
            ret_in = S_X5;
         end
         S_X5: begin
            if (ret_ff == S_X5 && (icode_ff == y86ie_pkg::I_MRMOV
                || icode_ff == y86ie_pkg::I_RET || icode_ff == y86ie_pkg::I_POP)
                && pend_ff == 1'b0 && i_ff == 3'd5) begin
               state_in = S_FSP;
            end
            state_in = S_FSP;
            unique case (icode_ff)
               y86ie_pkg::I_HALT: begin
                  st_in = y86ie_pkg::ST_HLT;
                  state_in = S_DONE;
               end
               y86ie_pkg::I_NOP: ;
               y86ie_pkg::I_RRMOV: begin
                  dor_in = cond;  rid_in = rb_ff;  rval_in = val_a;
               end
               y86ie_pkg::I_IRMOV: begin
                  dor_in = 1'b1;  rid_in = rb_ff;  rval_in = imm_ff;
               end
               y86ie_pkg::I_RMMOV: begin
                  if (daddr <= y86ie_pkg::WORD_LIM) begin
                     fa_in = daddr;  wd_in = val_a;  i_in = 3'd0;
                     ret_in = S_FSP;  state_in = S_WR;
                  end else begin
                     st_in = y86ie_pkg::ST_ADR;  state_in = S_DONE;
                  end
               end
               y86ie_pkg::I_MRMOV: begin
                  if (daddr <= y86ie_pkg::WORD_LIM) begin
                     fa_in = daddr;  n_in = 3'd4;  i_in = 3'd0;  buf_in = '0;
                     dor_in = 1'b1;  rid_in = ra_ff;
                     ret_in = S_FR;  state_in = S_RD;
                  end else begin
                     st_in = y86ie_pkg::ST_ADR;  state_in = S_DONE;
                  end
               end
               y86ie_pkg::I_OPL: begin
                  cc_in = alu_cc;
                  dor_in = 1'b1;  rid_in = rb_ff;  rval_in = alu_res;
               end
               y86ie_pkg::I_JXX: begin
                  if (cond) begin
                     np_in = imm_ff;
                  end
               end
               y86ie_pkg::I_CALL, y86ie_pkg::I_PUSH: begin
                  if (val_b - 32'd4 <= y86ie_pkg::WORD_LIM) begin
                     fa_in = val_b - 32'd4;  sp_in = val_b - 32'd4;  dosp_in = 1'b1;
                     i_in = 3'd0;  ret_in = S_FSP;  state_in = S_WR;
                     if (icode_ff == y86ie_pkg::I_CALL) begin
                        wd_in = np_ff;
                        np_in = imm_ff;
                     end else begin
                        wd_in = val_a;
                     end
                  end else begin
                     st_in = y86ie_pkg::ST_ADR;  state_in = S_DONE;
                  end
               end
               default: begin
                  if (val_b <= y86ie_pkg::WORD_LIM) begin
                     fa_in = val_b;  n_in = 3'd4;  i_in = 3'd0;  buf_in = '0;
                     sp_in = val_b + 32'd4;  dosp_in = 1'b1;
                     dor_in = icode_ff == y86ie_pkg::I_POP;  rid_in = ra_ff;
                     ret_in = S_FSP;  state_in = S_RD;
                  end else begin
                     st_in = y86ie_pkg::ST_ADR;  state_in = S_DONE;
                  end
               end
            endcase
         end
         S_FSP: begin
            if (icode_ff == y86ie_pkg::I_RET) begin
               np_in = buf_ff;
            end else if (icode_ff == y86ie_pkg::I_POP) begin
               rval_in = buf_ff;
            end
            if (dosp_ff) begin
               rf_req.we = 1'b1;
               rf_req.waddr = y86ie_pkg::REG_ESP;
               rf_req.wdata = sp_ff;
            end
            state_in = S_FR;
         end
         S_FR: begin
            if (icode_ff == y86ie_pkg::I_MRMOV) begin
               rf_req.wdata = buf_ff;
            end else begin
               rf_req.wdata = rval_ff;
            end
            rf_req.we = dor_ff && !rid_ff[3];
            rf_req.waddr = rid_ff[2:0];
            commit_in = 1'b1;
            state_in = S_DONE;
         end
         S_REG: begin
            data_in = rd_a;
            state_in = S_DONE;
         end
         S_WD: begin
            data_in = buf_ff;
            state_in = S_DONE;
         end
         default: begin
            if (!rv_ff || rsp_ch.ready) begin
               rv_in = 1'b1;
               rst_in = st_ff;
               rdat_in = data_ff;
               rcc_in = cc_ff;
               rpc_in = commit_ff ? np_ff : pc_ff;
               pc_in = commit_ff ? np_ff : pc_ff;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         pend_ff <= 1'b0;
         pc_ff <= '0;
         cc_ff <= y86ie_pkg::CC_RESET;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         pend_ff <= pend_in;
         pc_ff <= pc_in;
         cc_ff <= cc_in;
         rv_ff <= rv_in;
      end
      fa_ff <= fa_in;  n_ff <= n_in;  i_ff <= i_in;  pidx_ff <= pidx_in;
      buf_ff <= buf_in;  wd_ff <= wd_in;  ret_ff <= ret_in;
      icode_ff <= icode_in;  ifun_ff <= ifun_in;  ra_ff <= ra_in;  rb_ff <= rb_in;
      np_ff <= np_in;  imm_ff <= imm_in;  sp_ff <= sp_in;  rval_ff <= rval_in;
      dosp_ff <= dosp_in;  dor_ff <= dor_in;  rid_ff <= rid_in;  st_ff <= st_in;
      data_ff <= data_in;  commit_ff <= commit_in;
      rst_ff <= rst_in;  rpc_ff <= rpc_in;  rdat_ff <= rdat_in;  rcc_ff <= rcc_in;
   end
endmodule
`default_nettype wire

[src/y86ie_mem.sv]
// Byte-wide main memory, one port, registered read.
// Depends on y86ie_pkg.
`default_nettype none
module y86ie_mem (
   input  wire logic                      clock,
   input  wire y86ie_pkg::mem_req_type    mem_req,
   output logic [7:0]                     mem_rdata
);
   logic [7:0] ram_ff [y86ie_pkg::MEM_BYTES];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         ram_ff[mem_req.addr] <= mem_req.wdata;
      end
      mem_rdata <= ram_ff[mem_req.addr];
   end
endmodule
`default_nettype wire

[src/y86ie_regs.sv]
// Register file, eight words, one write and two registered reads.
// Depends on y86ie_pkg.
`default_nettype none
module y86ie_regs (
   input  wire logic                   clock,
   input  wire y86ie_pkg::rf_req_type  rf_req,
   output logic [31:0]                 rd_a,
   output logic [31:0]                 rd_b
);
   logic [31:0] rf_ff [8];

   always_ff @(posedge clock) begin
      if (rf_req.we) begin
         rf_ff[rf_req.waddr] <= rf_req.wdata;
      end
      rd_a <= rf_ff[rf_req.raddr_a];
      rd_b <= rf_ff[rf_req.raddr_b];
   end
endmodule
`default_nettype wire

[src/y86ie_alu.sv]
// ALU with condition codes and branch/move condition test.
// Depends on nothing outside this file.
`default_nettype none
module y86ie_alu (
   input  wire logic [3:0]  ifun,
   input  wire logic [31:0] val_a,
   input  wire logic [31:0] val_b,
   input  wire logic [2:0]  cc,
   output logic [31:0]      result,
   output logic [2:0]       cc_new,
   output logic             cond
);
   logic lt;
   logic ovf;

   always_comb begin
      unique case (ifun)
         4'd0:    result = val_a + val_b;
         4'd1:    result = val_b - val_a;
         4'd2:    result = val_a & val_b;
         4'd3:    result = val_a ^ val_b;
         default: result = '0;
      endcase
      ovf = 1'b0;
      if (ifun == 4'd0) begin
         ovf = (val_a[31] == val_b[31]) && (result[31] != val_a[31]);
      end else if (ifun == 4'd1) begin
         ovf = (val_a[31] != val_b[31]) && (result[31] != val_b[31]);
      end
      cc_new = {result == 32'd0, result[31], ovf};
   end

   always_comb begin
      lt = cc[1] != cc[0];
      unique case (ifun)
         4'd0:    cond = 1'b1;
         4'd1:    cond = cc[2] || lt;
         4'd2:    cond = lt;
         4'd3:    cond = cc[2];
         4'd4:    cond = !cc[2];
         4'd5:    cond = !lt;
         4'd6:    cond = !(cc[2] || lt);
         default: cond = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

[tb/y86ie_checker.sv]
// Checker for the Y86 executor: predicts each response from the accepted requests.
// Depends on y86ie_pkg and y86ie_if.
`timescale 1ns / 1ps
module y86ie_checker import y86ie_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   y86ie_req_if        req_ch,
   y86ie_rsp_if        rsp_ch,
   output int          fail_count,
   output int          pending,
   output int          rsp_total
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] program_counter;
      logic [2:0]  flags;
      logic [31:0] read_data;
   } outcome_t;

   logic [7:0]  mem_img [MEM_BYTES];
   logic [31:0] gpr [8];
   logic [31:0] pc_q;
   logic [2:0]  cc_q;
   outcome_t    outcome_q[$];

   function automatic logic byte_fits(logic [31:0] a);
      return a < BYTE_LIM;
   endfunction

   function automatic logic word_fits(logic [31:0] a);
      return a <= WORD_LIM;
   endfunction

   function automatic logic [31:0] word_at(logic [31:0] a);
      return {mem_img[a+3], mem_img[a+2], mem_img[a+1], mem_img[a]};
   endfunction

   function automatic logic [31:0] gpr_get(logic [3:0] id);
      return id < 8 ? gpr[id[2:0]] : 32'd0;
   endfunction

   function automatic logic cond_holds(logic [3:0] fn);
      logic lt;
      lt = cc_q[1] ^ cc_q[0];
      case (fn)
         4'd0: return 1'b1;
         4'd1: return cc_q[2] | lt;
         4'd2: return lt;
         4'd3: return cc_q[2];
         4'd4: return !cc_q[2];
         4'd5: return !lt;
         4'd6: return !(cc_q[2] | lt);
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic [1:0] run_instruction();
      logic [31:0] np, imm, adr, v, sp, a, b;
      logic [3:0]  icode, ifun, ra, rb;
      ra = 4'hF;
      rb = 4'hF;
      imm = '0;
      if (!byte_fits(pc_q)) return ST_ADR;
      icode = mem_img[pc_q][7:4];
      ifun = mem_img[pc_q][3:0];
      if (icode > I_POP) return ST_INS;
      np = pc_q + 1;
      if ((icode >= I_RRMOV && icode <= I_OPL) || icode == I_PUSH || icode == I_POP) begin
         if (!byte_fits(np)) return ST_ADR;
         ra = mem_img[np][7:4];
         rb = mem_img[np][3:0];
         np = np + 1;
      end
      if ((icode >= I_IRMOV && icode <= I_MRMOV) || icode == I_JXX || icode == I_CALL) begin
         if (!word_fits(np)) return ST_ADR;
         imm = word_at(np);
         np = np + 4;
      end
      case (icode)
         I_HALT: return ST_HLT;
         I_NOP: ;
         I_RRMOV: if (cond_holds(ifun) && rb < 8) gpr[rb[2:0]] = gpr_get(ra);
         I_IRMOV: if (rb < 8) gpr[rb[2:0]] = imm;
         I_RMMOV: begin
            adr = gpr_get(rb) + imm;
            if (!word_fits(adr)) return ST_ADR;
            v = gpr_get(ra);
            for (int k = 0; k < 4; k++) mem_img[adr+k] = v[8*k +: 8];
         end
         I_MRMOV: begin
            adr = gpr_get(rb) + imm;
            if (!word_fits(adr)) return ST_ADR;
            if (ra < 8) gpr[ra[2:0]] = word_at(adr);
         end
         I_OPL: begin
            a = gpr_get(ra);
            b = gpr_get(rb);
            case (ifun)
               4'd0: v = a + b;
               4'd1: v = b - a;
               4'd2: v = a & b;
               4'd3: v = a ^ b;
               default: v = '0;
            endcase
            cc_q[2] = (v == 0);
            cc_q[1] = v[31];
            cc_q[0] = (ifun == 0) ? (a[31] == b[31] && v[31] != a[31]) :
                      (ifun == 1) ? (a[31] != b[31] && v[31] != b[31]) : 1'b0;
            if (rb < 8) gpr[rb[2:0]] = v;
         end
         I_JXX: if (cond_holds(ifun)) np = imm;
         I_CALL: begin
            sp = gpr[REG_ESP] - 4;
            if (!word_fits(sp)) return ST_ADR;
            for (int k = 0; k < 4; k++) mem_img[sp+k] = np[8*k +: 8];
            gpr[REG_ESP] = sp;
            np = imm;
         end
         I_RET: begin
            sp = gpr[REG_ESP];
            if (!word_fits(sp)) return ST_ADR;
            np = word_at(sp);
            gpr[REG_ESP] = sp + 4;
         end
         I_PUSH: begin
            v = gpr_get(ra);
            sp = gpr[REG_ESP] - 4;
            if (!word_fits(sp)) return ST_ADR;
            for (int k = 0; k < 4; k++) mem_img[sp+k] = v[8*k +: 8];
            gpr[REG_ESP] = sp;
         end
         default: begin
            sp = gpr[REG_ESP];
            if (!word_fits(sp)) return ST_ADR;
            v = word_at(sp);
            gpr[REG_ESP] = sp + 4;
            if (ra < 8) gpr[ra[2:0]] = v;
         end
      endcase
      pc_q = np;
      return ST_AOK;
   endfunction

   function automatic outcome_t predict_outcome(logic [1:0] act, logic [12:0] adr,
                                                logic [7:0] lb, logic [2:0] ri);
      outcome_t o;
      o = '0;
      case (act)
         ACT_LOAD: if (byte_fits(32'(adr))) mem_img[adr] = lb;
         ACT_EXEC: o.status = run_instruction();
         ACT_REG:  o.read_data = gpr[ri];
         default:
            if (word_fits(32'(adr))) o.read_data = word_at(32'(adr));
            else o.status = ST_ADR;
      endcase
      o.program_counter = pc_q;
      o.flags = cc_q;
      return o;
   endfunction

   assign pending = outcome_q.size();

   always @(posedge clock) begin
      outcome_t e;
      if (reset) begin
         foreach (mem_img[i]) mem_img[i] = '0;
         foreach (gpr[i]) gpr[i] = '0;
         pc_q = '0;
         cc_q = CC_RESET;
         outcome_q.delete();
         fail_count = 0;
         rsp_total = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_total++;
            if (outcome_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response at %0t", $realtime);
            end else begin
               e = outcome_q.pop_front();
               if (e.status !== rsp_ch.status || e.program_counter !== rsp_ch.program_counter ||
                   e.flags !== rsp_ch.flags || e.read_data !== rsp_ch.read_data) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch #%0d: exp st=%0d pc=%h cc=%b rd=%h, got st=%0d pc=%h cc=%b rd=%h",
                              rsp_total, e.status, e.program_counter, e.flags, e.read_data,
                              rsp_ch.status, rsp_ch.program_counter, rsp_ch.flags,
                              rsp_ch.read_data);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            outcome_q.push_back(predict_outcome(req_ch.action, req_ch.address,
                                                req_ch.load_byte, req_ch.register_index));
      end
   end

endmodule

[tb/tb_y86_instruction_executor.sv]
// Top of the Y86 executor testbench: clock, reset, request stimulus and verdict.
// Depends on y86ie_pkg, y86ie_if, y86ie_checker and the block itself.
`timescale 1ns / 1ps
module tb_y86_instruction_executor;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, rsp_total;
   int   cycle_count = 0;
   int   item_count = 0;
   logic stim_done = 1'b0;

   y86ie_req_if req_ch ();
   y86ie_rsp_if rsp_ch ();

   y86_instruction_executor u_dut (.clock(clock), .reset(reset), .req_ch(req_ch),
                                   .rsp_ch(rsp_ch));
   y86ie_checker u_chk (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
                        .fail_count(fail_count), .pending(pending), .rsp_total(rsp_total));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.action = y86ie_pkg::ACT_LOAD;
      req_ch.address = '0;
      req_ch.load_byte = '0;
      req_ch.register_index = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("** y86_instruction_executor: FAILED **");
         $finish;
      end
   end

   // Receiver: random stall before each transfer.
   initial begin
      int w;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = $urandom_range(0, 4);
         if (w > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send(logic [1:0] act, logic [12:0] adr, logic [7:0] lb, logic [2:0] ri);
      int w;
      w = $urandom_range(0, 4);
      if (w > 0) begin
         req_ch.valid <= 1'b0;
         repeat (w) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.address <= adr;
      req_ch.load_byte <= lb;
      req_ch.register_index <= ri;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      item_count++;
   endtask

   task automatic put_byte(logic [12:0] adr, logic [7:0] b);
      send(y86ie_pkg::ACT_LOAD, adr, b, 3'($urandom));
   endtask

   task automatic put_word(logic [12:0] adr, logic [31:0] w);
      for (int k = 0; k < 4; k++) put_byte(adr + 13'(k), w[8*k +: 8]);
   endtask

   task automatic step();
      send(y86ie_pkg::ACT_EXEC, 13'($urandom), 8'($urandom), 3'($urandom));
   endtask

   // Random instruction at adr, sometimes with an invalid code; returns its length.
   task automatic put_instr(logic [12:0] adr, output int len);
      logic [3:0]  ic, fn, ra, rb;
      logic [31:0] imm;
      ic = 4'($urandom_range(0, 11));
      if ($urandom_range(0, 15) == 0) ic = 4'($urandom_range(12, 15));
      fn = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 6));
      if (ic == y86ie_pkg::I_OPL && $urandom_range(0, 3) != 0) fn = 4'($urandom_range(0, 3));
      ra = ($urandom_range(0, 7) == 0) ? 4'hF : 4'($urandom_range(0, 7));
      rb = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0: imm = 32'($urandom_range(0, 8191));
         1: imm = 32'($urandom_range(0, 255));
         2: imm = $urandom;
         default: imm = 32'(8192 - $urandom_range(0, 8));
      endcase
      if (ic == y86ie_pkg::I_JXX || ic == y86ie_pkg::I_CALL) imm = 32'($urandom_range(0, 1023));
      put_byte(adr, {ic, fn});
      len = 1;
      if ((ic >= y86ie_pkg::I_RRMOV && ic <= y86ie_pkg::I_OPL) || ic == y86ie_pkg::I_PUSH
          || ic == y86ie_pkg::I_POP) begin
         put_byte(adr + 13'(len), {ra, rb});
         len++;
      end
      if ((ic >= y86ie_pkg::I_IRMOV && ic <= y86ie_pkg::I_MRMOV) || ic == y86ie_pkg::I_JXX
          || ic == y86ie_pkg::I_CALL) begin
         put_word(adr + 13'(len), imm);
         len += 4;
      end
   endtask

   initial begin
      int len, pc;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: edges of memory, several instruction classes, halt, bad code, bad address
      put_byte(13'd8191, 8'hFF);
      send(y86ie_pkg::ACT_WORD, 13'd8188, 8'h00, 3'd0);
      send(y86ie_pkg::ACT_WORD, 13'd8189, 8'h00, 3'd0);
      put_byte(0, {y86ie_pkg::I_IRMOV, 4'h0}); put_byte(1, 8'hF4); put_word(2, 32'h0000_1000);
      step();
      put_byte(6, {y86ie_pkg::I_OPL, 4'h1}); put_byte(7, 8'h44);
      step();
      put_byte(8, {y86ie_pkg::I_CALL, 4'h0}); put_word(9, 32'd20);
      step();
      put_byte(20, {y86ie_pkg::I_RET, 4'h0});
      step();
      put_byte(13, {y86ie_pkg::I_HALT, 4'h0});
      step();
      send(y86ie_pkg::ACT_REG, 0, 0, 3'd4);
      send(y86ie_pkg::ACT_REG, 0, 0, 3'd7);
      put_byte(13, 8'hC0);
      step();
      put_byte(13, {y86ie_pkg::I_IRMOV, 4'h0}); put_byte(14, 8'hF4);
      put_word(15, 32'hFFFF_FFFF);
      step();
      put_byte(19, {y86ie_pkg::I_PUSH, 4'h0}); put_byte(20, 8'h0F);
      step();
      // random: short programs written then run, plus plain random items
      while (item_count < 600) begin
         case ($urandom_range(0, 9))
            0: put_byte(13'($urandom), 8'($urandom));
            1: send(y86ie_pkg::ACT_REG, 13'($urandom), 8'($urandom), 3'($urandom));
            2: send(y86ie_pkg::ACT_WORD, ($urandom_range(0, 1) != 0)
                    ? 13'($urandom_range(8180, 8191)) : 13'($urandom), 0, 0);
            default: begin
               pc = $urandom_range(0, 900);
               // reposition PC with an immediate jump at the current PC is awkward;
               // instead build sequentially from 0 via a jump
               put_byte(0, {y86ie_pkg::I_JXX, 4'h0});
               put_word(1, 32'(pc));
               for (int i = 0; i < 4; i++) begin
                  put_instr(13'(pc), len);
                  pc += len;
               end
               if ($urandom_range(0, 3) == 0)
                  send(y86ie_pkg::ACT_EXEC, 0, 0, 0);
               for (int i = 0; i < 5; i++) step();
               put_byte(13'($urandom_range(0, 15)), 8'($urandom));
            end
         endcase
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("run: %0d requests sent, %0d responses checked (loads, programs, reads)",
               item_count, rsp_total);
      if (fail_count == 0 && pending == 0) $display("** y86_instruction_executor: PASSED **");
      else $display("** y86_instruction_executor: FAILED **");
      $finish;
   end

endmodule
